// ----- hw/rtl/sip_pkg.sv -----
// Shared constants, types and helpers of the segment intersection block.
`timescale 1ns / 1ps
package sip_pkg;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int CEPS_W          = 20;
    localparam int PEPS_W          = 8;
    localparam int CFG_IDX_W       = 8;
    localparam int CFG_DATA_W      = 32;

    localparam logic [CEPS_W-1:0]    CROSS_EPS_RST = 20'd16;
    localparam logic [PEPS_W-1:0]    POINT_EPS_RST = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CROSS_EPS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_EPS = 8'd1;

    // Coordinate slots inside the packed input vector.
    localparam int IDX_AX  = 0;
    localparam int IDX_AY  = 1;
    localparam int IDX_A2X = 2;
    localparam int IDX_A2Y = 3;
    localparam int IDX_BX  = 4;
    localparam int IDX_BY  = 5;
    localparam int IDX_B2X = 6;
    localparam int IDX_B2Y = 7;

    typedef struct packed {
        logic       gen;
        logic       col;
        logic [3:0] mask;
        logic       neg_x;
        logic       neg_y;
    } side_t;

    // Candidate points of the collinear case, in output order: B1, B2, A1, A2.
    function automatic int slot_x_idx(input int slot);
        int r;
        begin
            case (slot)
                0:       r = IDX_BX;
                1:       r = IDX_B2X;
                2:       r = IDX_AX;
                default: r = IDX_A2X;
            endcase
            return r;
        end
    endfunction
endpackage

// ----- hw/rtl/sip_front.sv -----
// Front stages: direction vectors, partial products, cross products and box tests.
`timescale 1ns / 1ps
module sip_front #(
    parameter int W = sip_pkg::COORD_WIDTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [8*W-1:0]          in_coords,
    output logic                    out_valid,
    output logic [8*W-1:0]          out_coords,
    output logic signed [2*W+2:0]   out_den,
    output logic signed [2*W+2:0]   out_tn,
    output logic signed [2*W+2:0]   out_un,
    output logic [3:0]              out_box
);
    localparam int DW = W + 1;
    localparam int PW = 2 * DW;
    localparam int CW = PW + 1;

    logic                 v1_reg, v2_reg, v3_reg;
    logic [8*W-1:0]       c1_reg, c2_reg, c3_reg;
    logic signed [DW-1:0] rx_reg, ry_reg, sx_reg, sy_reg, qx_reg, qy_reg;
    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic [3:0]           box2_reg, box3_reg;
    logic signed [CW-1:0] den_reg, tn_reg, un_reg;

    logic signed [W-1:0]  ax, ay, a2x, a2y, bx, by, b2x, b2y;
    logic signed [W-1:0]  ax1, ay1, a2x1, a2y1, bx1, by1, b2x1, b2y1;
    logic [3:0]           box_next;

    function automatic logic in_box(input logic signed [W-1:0] px, input logic signed [W-1:0] py,
                                    input logic signed [W-1:0] x0, input logic signed [W-1:0] y0,
                                    input logic signed [W-1:0] x1, input logic signed [W-1:0] y1);
        logic okx, oky;
        begin
            okx = (x0 <= px && px <= x1) || (x1 <= px && px <= x0);
            oky = (y0 <= py && py <= y1) || (y1 <= py && py <= y0);
            return okx && oky;
        end
    endfunction

    assign ax  = $signed(in_coords[sip_pkg::IDX_AX*W  +: W]);
    assign ay  = $signed(in_coords[sip_pkg::IDX_AY*W  +: W]);
    assign a2x = $signed(in_coords[sip_pkg::IDX_A2X*W +: W]);
    assign a2y = $signed(in_coords[sip_pkg::IDX_A2Y*W +: W]);
    assign bx  = $signed(in_coords[sip_pkg::IDX_BX*W  +: W]);
    assign by  = $signed(in_coords[sip_pkg::IDX_BY*W  +: W]);
    assign b2x = $signed(in_coords[sip_pkg::IDX_B2X*W +: W]);
    assign b2y = $signed(in_coords[sip_pkg::IDX_B2Y*W +: W]);

    assign ax1  = $signed(c1_reg[sip_pkg::IDX_AX*W  +: W]);
    assign ay1  = $signed(c1_reg[sip_pkg::IDX_AY*W  +: W]);
    assign a2x1 = $signed(c1_reg[sip_pkg::IDX_A2X*W +: W]);
    assign a2y1 = $signed(c1_reg[sip_pkg::IDX_A2Y*W +: W]);
    assign bx1  = $signed(c1_reg[sip_pkg::IDX_BX*W  +: W]);
    assign by1  = $signed(c1_reg[sip_pkg::IDX_BY*W  +: W]);
    assign b2x1 = $signed(c1_reg[sip_pkg::IDX_B2X*W +: W]);
    assign b2y1 = $signed(c1_reg[sip_pkg::IDX_B2Y*W +: W]);

    always_comb begin
        box_next[0] = in_box(bx1, by1, ax1, ay1, a2x1, a2y1);
        box_next[1] = in_box(b2x1, b2y1, ax1, ay1, a2x1, a2y1);
        box_next[2] = in_box(ax1, ay1, bx1, by1, b2x1, b2y1);
        box_next[3] = in_box(a2x1, a2y1, bx1, by1, b2x1, b2y1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c1_reg   <= in_coords;
            rx_reg   <= DW'(a2x) - DW'(ax);
            ry_reg   <= DW'(a2y) - DW'(ay);
            sx_reg   <= DW'(b2x) - DW'(bx);
            sy_reg   <= DW'(b2y) - DW'(by);
            qx_reg   <= DW'(bx) - DW'(ax);
            qy_reg   <= DW'(by) - DW'(ay);
            c2_reg   <= c1_reg;
            p0_reg   <= rx_reg * sy_reg;
            p1_reg   <= ry_reg * sx_reg;
            p2_reg   <= qx_reg * sy_reg;
            p3_reg   <= qy_reg * sx_reg;
            p4_reg   <= qx_reg * ry_reg;
            p5_reg   <= qy_reg * rx_reg;
            box2_reg <= box_next;
            c3_reg   <= c2_reg;
            den_reg  <= CW'(p0_reg) - CW'(p1_reg);
            tn_reg   <= CW'(p2_reg) - CW'(p3_reg);
            un_reg   <= CW'(p4_reg) - CW'(p5_reg);
            box3_reg <= box2_reg;
        end
    end

    assign out_valid  = v3_reg;
    assign out_coords = c3_reg;
    assign out_den    = den_reg;
    assign out_tn     = tn_reg;
    assign out_un     = un_reg;
    assign out_box    = box3_reg;
endmodule

// ----- hw/rtl/sip_classify.sv -----
// Case decision, collinear point selection and scaled numerator products.
`timescale 1ns / 1ps
module sip_classify #(
    parameter int W = sip_pkg::COORD_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic [sip_pkg::CEPS_W-1:0]    cross_eps,
    input  logic [sip_pkg::PEPS_W-1:0]    point_eps,
    input  logic                          in_valid,
    input  logic [8*W-1:0]                in_coords,
    input  logic signed [2*W+2:0]         in_den,
    input  logic signed [2*W+2:0]         in_tn,
    input  logic signed [2*W+2:0]         in_un,
    input  logic [3:0]                    in_box,
    output logic                          out_valid,
    output sip_pkg::side_t                out_side,
    output logic [8*W-1:0]                out_coords,
    output logic [4*W+4:0]                out_nx,
    output logic [4*W+4:0]                out_ny,
    output logic [2*W+2:0]                out_d2
);
    localparam int CW = 2 * W + 3;
    localparam int MW = W + 1;
    localparam int NW = CW - 1 + MW;
    localparam int RW = NW + 2;
    localparam int EW = (CW > sip_pkg::CEPS_W) ? CW : sip_pkg::CEPS_W;

    logic                 v4_reg, v5_reg;
    sip_pkg::side_t       side4_reg, side5_reg;
    logic [8*W-1:0]       c4_reg, c5_reg;
    logic [CW-2:0]        tn4_reg, den4_reg;
    logic [MW-1:0]        mx4_reg, my4_reg;
    logic [RW-1:0]        nx5_reg, ny5_reg;
    logic [CW-1:0]        d25_reg;

    sip_pkg::side_t       side_next;
    logic signed [CW-1:0] den_n, tn_n, un_n;
    logic [CW-1:0]        den_mag, un_mag;
    logic                 den_small, un_small;
    logic signed [MW-1:0] rx, ry;
    logic [3:0]           keep;
    logic                 dup;
    logic [NW-1:0]        prod_x, prod_y;

    function automatic logic close_pts(input logic [8*W-1:0] c, input int i, input int j,
                                       input logic [sip_pkg::PEPS_W-1:0] eps);
        logic signed [W:0] dx, dy;
        logic [W:0]        mx, my;
        begin
            dx = (W+1)'($signed(c[sip_pkg::slot_x_idx(i)*W +: W]))
               - (W+1)'($signed(c[sip_pkg::slot_x_idx(j)*W +: W]));
            dy = (W+1)'($signed(c[(sip_pkg::slot_x_idx(i)+1)*W +: W]))
               - (W+1)'($signed(c[(sip_pkg::slot_x_idx(j)+1)*W +: W]));
            mx = dx[W] ? (W+1)'(-dx) : (W+1)'(dx);
            my = dy[W] ? (W+1)'(-dy) : (W+1)'(dy);
            return (mx <= (W+1)'(eps)) && (my <= (W+1)'(eps));
        end
    endfunction

    always_comb begin
        den_mag   = in_den[CW-1] ? CW'(-in_den) : CW'(in_den);
        un_mag    = in_un[CW-1] ? CW'(-in_un) : CW'(in_un);
        den_small = EW'(den_mag) < EW'(cross_eps);
        un_small  = EW'(un_mag) < EW'(cross_eps);
        den_n     = in_den[CW-1] ? -in_den : in_den;
        tn_n      = in_den[CW-1] ? -in_tn : in_tn;
        un_n      = in_den[CW-1] ? -in_un : in_un;
        rx = MW'($signed(in_coords[sip_pkg::IDX_A2X*W +: W]))
           - MW'($signed(in_coords[sip_pkg::IDX_AX*W +: W]));
        ry = MW'($signed(in_coords[sip_pkg::IDX_A2Y*W +: W]))
           - MW'($signed(in_coords[sip_pkg::IDX_AY*W +: W]));

        // The first two kept points decide whether the last kept one is a duplicate.
        dup = 1'b0;
        for (int i = 0; i < 4; i++) begin
            for (int j = i + 1; j < 4; j++) begin
                if (in_box[i] && in_box[j] && ((in_box & ((4'b1 << j) - 4'b1)) == (4'b1 << i))
                    && close_pts(in_coords, i, j, point_eps)) begin
                    dup = 1'b1;
                end
            end
        end
        keep = in_box;
        if (dup) begin
            if (in_box[3]) begin
                keep[3] = 1'b0;
            end else if (in_box[2]) begin
                keep[2] = 1'b0;
            end else begin
                keep[1] = 1'b0;
            end
        end

        side_next       = '0;
        side_next.neg_x = rx[MW-1];
        side_next.neg_y = ry[MW-1];
        if (den_small) begin
            if (un_small) begin
                side_next.col  = 1'b1;
                side_next.mask = keep;
            end
        end else if (in_den != '0) begin
            side_next.gen = !tn_n[CW-1] && !un_n[CW-1] && (tn_n <= den_n) && (un_n <= den_n);
        end
    end

    assign prod_x = NW'(tn4_reg) * NW'(mx4_reg);
    assign prod_y = NW'(tn4_reg) * NW'(my4_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= in_valid;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side4_reg <= side_next;
            c4_reg    <= in_coords;
            tn4_reg   <= tn_n[CW-2:0];
            den4_reg  <= den_n[CW-2:0];
            mx4_reg   <= rx[MW-1] ? MW'(-rx) : MW'(rx);
            my4_reg   <= ry[MW-1] ? MW'(-ry) : MW'(ry);
            side5_reg <= side4_reg;
            c5_reg    <= c4_reg;
            nx5_reg   <= (RW'(prod_x) << 1) + RW'(den4_reg);
            ny5_reg   <= (RW'(prod_y) << 1) + RW'(den4_reg);
            d25_reg   <= {den4_reg, 1'b0};
        end
    end

    assign out_valid  = v5_reg;
    assign out_side   = side5_reg;
    assign out_coords = c5_reg;
    assign out_nx     = (4*W+5)'(nx5_reg);
    assign out_ny     = (4*W+5)'(ny5_reg);
    assign out_d2     = d25_reg;
endmodule

// ----- hw/rtl/sip_divider.sv -----
// Pipelined restoring divider, one quotient bit per stage, for both coordinates.
`timescale 1ns / 1ps
module sip_divider #(
    parameter int W = sip_pkg::COORD_WIDTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  sip_pkg::side_t   in_side,
    input  logic [8*W-1:0]   in_coords,
    input  logic [4*W+4:0]   in_nx,
    input  logic [4*W+4:0]   in_ny,
    input  logic [2*W+2:0]   in_d2,
    output logic             out_valid,
    output sip_pkg::side_t   out_side,
    output logic [8*W-1:0]   out_coords,
    output logic [W:0]       out_qx,
    output logic [W:0]       out_qy
);
    localparam int Q  = W + 1;
    localparam int CW = 2 * W + 3;
    localparam int RW = 4 * W + 5;

    logic           v_a [Q+1];
    sip_pkg::side_t s_a [Q+1];
    logic [8*W-1:0] c_a [Q+1];
    logic [RW-1:0]  nx_a [Q+1];
    logic [RW-1:0]  ny_a [Q+1];
    logic [CW-1:0]  d_a [Q+1];
    logic [Q-1:0]   qx_a [Q+1];
    logic [Q-1:0]   qy_a [Q+1];

    assign v_a[0]  = in_valid;
    assign s_a[0]  = in_side;
    assign c_a[0]  = in_coords;
    assign nx_a[0] = in_nx;
    assign ny_a[0] = in_ny;
    assign d_a[0]  = in_d2;
    assign qx_a[0] = '0;
    assign qy_a[0] = '0;

    for (genvar k = 0; k < Q; k++) begin : g_stage
        localparam int B = Q - 1 - k;
        logic [RW-1:0] dsh;
        logic          gex, gey;
        logic [Q-1:0]  qx_next, qy_next;

        always_comb begin
            dsh          = RW'(d_a[k]) << B;
            gex          = nx_a[k] >= dsh;
            gey          = ny_a[k] >= dsh;
            qx_next      = qx_a[k];
            qy_next      = qy_a[k];
            qx_next[B]   = gex;
            qy_next[B]   = gey;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_a[k+1] <= 1'b0;
            end else if (en) begin
                v_a[k+1] <= v_a[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                s_a[k+1]  <= s_a[k];
                c_a[k+1]  <= c_a[k];
                d_a[k+1]  <= d_a[k];
                nx_a[k+1] <= gex ? nx_a[k] - dsh : nx_a[k];
                ny_a[k+1] <= gey ? ny_a[k] - dsh : ny_a[k];
                qx_a[k+1] <= qx_next;
                qy_a[k+1] <= qy_next;
            end
        end
    end

    assign out_valid  = v_a[Q];
    assign out_side   = s_a[Q];
    assign out_coords = c_a[Q];
    assign out_qx     = qx_a[Q];
    assign out_qy     = qy_a[Q];
endmodule

// ----- hw/rtl/sip_out.sv -----
// Output register that releases the one to four results of an item in turn.
`timescale 1ns / 1ps
module sip_out #(
    parameter int W = sip_pkg::COORD_WIDTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    output logic             en,
    input  logic             in_valid,
    input  sip_pkg::side_t   in_side,
    input  logic [8*W-1:0]   in_coords,
    input  logic [W:0]       in_qx,
    input  logic [W:0]       in_qy,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [2*W-1:0]   m_axis_tdata,
    output logic [1:0]       m_axis_tuser,
    output logic             m_axis_tlast
);
    logic             hold_valid_reg, hold_valid_next;
    logic [3:0]       mask_reg, mask_next;
    logic             col_reg;
    logic [W-1:0]     px_reg [4];
    logic [W-1:0]     py_reg [4];

    logic             last_now, load;
    logic [1:0]       slot;
    logic signed [W+1:0] gx, gy, qxs, qys;

    always_comb begin
        slot = 2'd3;
        if (mask_reg[0]) begin
            slot = 2'd0;
        end else if (mask_reg[1]) begin
            slot = 2'd1;
        end else if (mask_reg[2]) begin
            slot = 2'd2;
        end
        last_now = (mask_reg & (mask_reg - 4'd1)) == 4'd0;
        en       = !hold_valid_reg || (m_axis_tready && last_now);
        load     = en && in_valid;

        qxs = $signed((W+2)'(in_qx));
        qys = $signed((W+2)'(in_qy));
        gx  = (W+2)'($signed(in_coords[sip_pkg::IDX_AX*W +: W])) + (in_side.neg_x ? -qxs : qxs);
        gy  = (W+2)'($signed(in_coords[sip_pkg::IDX_AY*W +: W])) + (in_side.neg_y ? -qys : qys);

        hold_valid_next = hold_valid_reg;
        mask_next       = mask_reg;
        if (load) begin
            hold_valid_next = 1'b1;
            mask_next       = in_side.gen ? 4'b0001 : in_side.mask;
        end else if (en) begin
            hold_valid_next = 1'b0;
        end else if (m_axis_tready) begin
            mask_next = mask_reg & (mask_reg - 4'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            mask_reg       <= '0;
        end else begin
            hold_valid_reg <= hold_valid_next;
            mask_reg       <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            col_reg <= in_side.col;
            for (int i = 0; i < 4; i++) begin
                if (in_side.gen && i == 0) begin
                    px_reg[i] <= gx[W-1:0];
                    py_reg[i] <= gy[W-1:0];
                end else begin
                    px_reg[i] <= in_coords[sip_pkg::slot_x_idx(i)*W +: W];
                    py_reg[i] <= in_coords[(sip_pkg::slot_x_idx(i)+1)*W +: W];
                end
            end
        end
    end

    assign m_axis_tvalid = hold_valid_reg;
    assign m_axis_tdata  = (mask_reg == 4'd0) ? '0 : {py_reg[slot], px_reg[slot]};
    assign m_axis_tuser  = {col_reg, mask_reg != 4'd0};
    assign m_axis_tlast  = last_now;
endmodule

// ----- hw/rtl/segment_intersection_points.sv -----
// Top level of the segment intersection block with its configuration registers.
`timescale 1ns / 1ps
// Takes one segment pair per cycle while not stalled and returns the intersection
// point, the kept endpoints of a collinear overlap (up to four results, the last
// marked by tlast), or one invalid result. Three stages form the cross products, two
// decide the case and form the scaled numerators, one stage per quotient bit divides,
// and the output register holds the result. An item that yields several results holds
// the output register until its last result is taken, and the pipeline stalls meanwhile
// and while a held result is not taken; otherwise the throughput is one pair per cycle.
module segment_intersection_points #(
    parameter int COORD_WIDTH = sip_pkg::COORD_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
    input  logic [8*COORD_WIDTH-1:0]           s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // point_x, point_y
    output logic [2*COORD_WIDTH-1:0]           m_axis_tdata,
    // point_valid, collinear_case
    output logic [1:0]                         m_axis_tuser,
    output logic                               m_axis_tlast,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sip_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sip_pkg::CFG_DATA_W-1:0]     cfg_data
);
    localparam int W = COORD_WIDTH;

    logic [sip_pkg::CEPS_W-1:0] cross_eps_reg;
    logic [sip_pkg::PEPS_W-1:0] point_eps_reg;
    logic                       en;

    logic                       f_valid;
    logic [8*W-1:0]             f_coords;
    logic signed [2*W+2:0]      f_den, f_tn, f_un;
    logic [3:0]                 f_box;

    logic                       c_valid;
    sip_pkg::side_t             c_side;
    logic [8*W-1:0]             c_coords;
    logic [4*W+4:0]             c_nx, c_ny;
    logic [2*W+2:0]             c_d2;

    logic                       d_valid;
    sip_pkg::side_t             d_side;
    logic [8*W-1:0]             d_coords;
    logic [W:0]                 d_qx, d_qy;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cross_eps_reg <= sip_pkg::CROSS_EPS_RST;
            point_eps_reg <= sip_pkg::POINT_EPS_RST;
        end else if (cfg_valid) begin
            if (cfg_index == sip_pkg::REG_CROSS_EPS) begin
                cross_eps_reg <= cfg_data[sip_pkg::CEPS_W-1:0];
            end else if (cfg_index == sip_pkg::REG_POINT_EPS) begin
                point_eps_reg <= cfg_data[sip_pkg::PEPS_W-1:0];
            end
        end
    end

    sip_front #(.W(W)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s_axis_tvalid),
        .in_coords  (s_axis_tdata),
        .out_valid  (f_valid),
        .out_coords (f_coords),
        .out_den    (f_den),
        .out_tn     (f_tn),
        .out_un     (f_un),
        .out_box    (f_box)
    );

    sip_classify #(.W(W)) u_classify (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .cross_eps  (cross_eps_reg),
        .point_eps  (point_eps_reg),
        .in_valid   (f_valid),
        .in_coords  (f_coords),
        .in_den     (f_den),
        .in_tn      (f_tn),
        .in_un      (f_un),
        .in_box     (f_box),
        .out_valid  (c_valid),
        .out_side   (c_side),
        .out_coords (c_coords),
        .out_nx     (c_nx),
        .out_ny     (c_ny),
        .out_d2     (c_d2)
    );

    sip_divider #(.W(W)) u_divider (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (c_valid),
        .in_side    (c_side),
        .in_coords  (c_coords),
        .in_nx      (c_nx),
        .in_ny      (c_ny),
        .in_d2      (c_d2),
        .out_valid  (d_valid),
        .out_side   (d_side),
        .out_coords (d_coords),
        .out_qx     (d_qx),
        .out_qy     (d_qy)
    );

    sip_out #(.W(W)) u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .in_valid      (d_valid),
        .in_side       (d_side),
        .in_coords     (d_coords),
        .in_qx         (d_qx),
        .in_qy         (d_qy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    a_single_general: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tlast)
        else $error("non-collinear result is not the last of its item");

    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && m_axis_tdata == '0)
        else $error("invalid result is not a single zero result");

    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && m_axis_tuser[1])
        else $error("collinear run broken before its last result");
endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the segment intersection block.
`timescale 1ns / 1ps
module testbench;
    localparam int CW = sip_pkg::COORD_WIDTH_DEF;
    localparam int LATENCY = CW + 7;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [sip_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 8'd2;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 valid;
        logic                 col;
        logic                 last;
    } point_result_t;

    typedef struct {
        logic [8*CW-1:0] coords;
        bit              typed;
        point_result_t   want;
    } stim_row_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [8*CW-1:0]                 s_axis_tdata;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [2*CW-1:0]                 m_axis_tdata;
    logic [1:0]                      m_axis_tuser;
    logic                            m_axis_tlast;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [sip_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [sip_pkg::CFG_DATA_W-1:0]  cfg_data;

    logic [sip_pkg::CEPS_W-1:0] area_eps;
    logic [sip_pkg::PEPS_W-1:0] coord_eps;

    point_result_t pending_points[$];
    stim_row_t     directed_rows[$];
    bit            typed_next;
    point_result_t typed_want;

    int  errors = 0;
    int  cycles = 0;
    int  items_sent;
    int  points_seen = 0;
    int  collinear_seen = 0;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  hold_cycles;
    bit  hold_request;
    bit  hold_done;

    segment_intersection_points DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint abs_l(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic bit inside_box(input longint px, py, ax, ay, bx, by);
        longint lx, hx, ly, hy;
        lx = ax < bx ? ax : bx;
        hx = ax < bx ? bx : ax;
        ly = ay < by ? ay : by;
        hy = ay < by ? by : ay;
        return px >= lx && px <= hx && py >= ly && py <= hy;
    endfunction

    function automatic longint round_scaled(input longint tn, den, rv);
        longint q;
        q = (2 * tn * abs_l(rv) + den) / (2 * den);
        return rv < 0 ? -q : q;
    endfunction

    function automatic point_result_t make_point(input longint x, y, input bit v, c, l);
        point_result_t p;
        p.x = x[CW-1:0];
        p.y = y[CW-1:0];
        p.valid = v;
        p.col = c;
        p.last = l;
        return p;
    endfunction

    task automatic queue_result(input point_result_t p);
        pending_points = {pending_points, p};
    endtask

    // Works out the results of one segment pair under the current register values.
    task automatic predict_points(input logic [8*CW-1:0] d);
        longint c[8];
        longint rx, ry, sxv, syv, qx, qy, den, tn, un;
        longint kx[4], ky[4];
        int n;
        for (int i = 0; i < 8; i++) c[i] = longint'($signed(d[i*CW +: CW]));
        rx = c[sip_pkg::IDX_A2X] - c[sip_pkg::IDX_AX];
        ry = c[sip_pkg::IDX_A2Y] - c[sip_pkg::IDX_AY];
        sxv = c[sip_pkg::IDX_B2X] - c[sip_pkg::IDX_BX];
        syv = c[sip_pkg::IDX_B2Y] - c[sip_pkg::IDX_BY];
        qx = c[sip_pkg::IDX_BX] - c[sip_pkg::IDX_AX];
        qy = c[sip_pkg::IDX_BY] - c[sip_pkg::IDX_AY];
        den = rx * syv - ry * sxv;
        tn = qx * syv - qy * sxv;
        un = qx * ry - qy * rx;
        if (abs_l(den) < longint'(area_eps)) begin
            if (abs_l(un) >= longint'(area_eps)) begin
                queue_result(make_point(0, 0, 0, 0, 1));
                return;
            end
            n = 0;
            for (int k = 0; k < 4; k++) begin
                longint px, py;
                bit keep;
                px = c[sip_pkg::slot_x_idx(k)];
                py = c[sip_pkg::slot_x_idx(k) + 1];
                if (k < 2)
                    keep = inside_box(px, py, c[sip_pkg::IDX_AX], c[sip_pkg::IDX_AY],
                                      c[sip_pkg::IDX_A2X], c[sip_pkg::IDX_A2Y]);
                else
                    keep = inside_box(px, py, c[sip_pkg::IDX_BX], c[sip_pkg::IDX_BY],
                                      c[sip_pkg::IDX_B2X], c[sip_pkg::IDX_B2Y]);
                if (keep) begin
                    kx[n] = px;
                    ky[n] = py;
                    n++;
                end
            end
            if (n > 1 && abs_l(kx[0] - kx[1]) <= longint'(coord_eps)
                    && abs_l(ky[0] - ky[1]) <= longint'(coord_eps))
                n--;
            if (n == 0)
                queue_result(make_point(0, 0, 0, 1, 1));
            for (int k = 0; k < n; k++)
                queue_result(make_point(kx[k], ky[k], 1, 1, k == n - 1));
            return;
        end
        if (den == 0) begin
            queue_result(make_point(0, 0, 0, 0, 1));
            return;
        end
        if (den < 0) begin
            den = -den;
            tn = -tn;
            un = -un;
        end
        if (tn < 0 || un < 0 || tn > den || un > den) begin
            queue_result(make_point(0, 0, 0, 0, 1));
            return;
        end
        queue_result(make_point(c[sip_pkg::IDX_AX] + round_scaled(tn, den, rx),
                                c[sip_pkg::IDX_AY] + round_scaled(tn, den, ry), 1, 0, 1));
    endtask

    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            if (typed_next)
                queue_result(typed_want);
            else
                predict_points(s_axis_tdata);
        end
    end

    always @(posedge aclk) begin
        point_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_points.size() == 0) begin
                $display("%0t: unexpected transfer x=%0d y=%0d", $time,
                         $signed(m_axis_tdata[CW-1:0]), $signed(m_axis_tdata[2*CW-1:CW]));
                errors++;
            end else begin
                want = pending_points.pop_front();
                if (m_axis_tdata !== {want.y, want.x} || m_axis_tuser !== {want.col, want.valid}
                        || m_axis_tlast !== want.last) begin
                    $display("%0t: expected x=%0d y=%0d valid=%0b col=%0b last=%0b",
                             $time, want.x, want.y, want.valid, want.col, want.last);
                    $display("%0t: actual   x=%0d y=%0d valid=%0b col=%0b last=%0b",
                             $time, $signed(m_axis_tdata[CW-1:0]),
                             $signed(m_axis_tdata[2*CW-1:CW]),
                             m_axis_tuser[0], m_axis_tuser[1], m_axis_tlast);
                    errors++;
                end
                if (want.valid) points_seen++;
                if (want.col) collinear_seen++;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            hold_cycles <= 0;
            hold_done <= 1'b0;
        end else if (hold_request && !hold_done && hold_cycles == 0) begin
            hold_cycles <= 300;
            hold_done <= 1'b1;
            m_axis_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= $urandom_range(99) >= recv_idle_pct;
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [8*CW-1:0] pack_pair(input longint v[8]);
        logic [8*CW-1:0] d;
        for (int i = 0; i < 8; i++) d[i*CW +: CW] = v[i][CW-1:0];
        return d;
    endfunction

    task automatic add_row(input longint v[8], input bit typed, input point_result_t want);
        stim_row_t r;
        r.coords = pack_pair(v);
        r.typed = typed;
        r.want = want;
        directed_rows = {directed_rows, r};
    endtask

    task automatic send_pair(input logic [8*CW-1:0] d, input bit typed, input point_result_t want);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        typed_next <= typed;
        typed_want <= want;
        do @(posedge aclk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        typed_next <= 1'b0;
        @(posedge aclk);
        while (pending_points.size() != 0) @(posedge aclk);
        repeat (LATENCY + 20) @(posedge aclk);
    endtask

    task automatic write_register(input logic [sip_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [sip_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == sip_pkg::REG_CROSS_EPS)
            area_eps = val[sip_pkg::CEPS_W-1:0];
        else if (idx == sip_pkg::REG_POINT_EPS)
            coord_eps = val[sip_pkg::PEPS_W-1:0];
        @(posedge aclk);
    endtask

    // Builds one random pair, mostly of shapes that reach the intersection and overlap paths.
    function automatic logic [8*CW-1:0] random_pair();
        longint v[8];
        longint px, py, dx, dy, ox, oy;
        int kind;
        kind = $urandom_range(99);
        if (kind < 40) begin
            for (int i = 0; i < 8; i++) v[i] = $urandom_range(400) - 200;
        end else if (kind < 75) begin
            px = $urandom_range(20000) - 10000;
            py = $urandom_range(20000) - 10000;
            dx = $urandom_range(40) - 20;
            dy = $urandom_range(40) - 20;
            ox = 0;
            oy = 0;
            if (kind >= 65) begin
                ox = $urandom_range(60) - 30;
                oy = $urandom_range(60) - 30;
            end
            for (int i = 0; i < 4; i++) begin
                longint k;
                k = $urandom_range(80) - 40;
                v[2*i] = px + k * dx + (i >= 2 ? ox : 0);
                v[2*i+1] = py + k * dy + (i >= 2 ? oy : 0);
            end
        end else if (kind < 90) begin
            for (int i = 0; i < 8; i++) v[i] = longint'($signed(16'($urandom)));
        end else begin
            for (int i = 0; i < 8; i++) v[i] = $urandom_range(2000) - 1000;
            v[sip_pkg::IDX_BX] = v[sip_pkg::IDX_A2X];
            v[sip_pkg::IDX_BY] = v[sip_pkg::IDX_A2Y];
        end
        return pack_pair(v);
    endfunction

    task automatic run_random(input int count);
        point_result_t none;
        none = make_point(0, 0, 0, 0, 0);
        for (int i = 0; i < count; i++) send_pair(random_pair(), 1'b0, none);
    endtask

    initial begin
        point_result_t none;
        none = make_point(0, 0, 0, 0, 0);
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        typed_next = 1'b0;
        hold_request = 1'b0;
        items_sent = 0;
        area_eps = sip_pkg::CROSS_EPS_RST;
        coord_eps = sip_pkg::POINT_EPS_RST;
        send_idle_pct = 26;
        recv_idle_pct = 73;

        add_row('{0, 0, 32, 32, 0, 32, 32, 0}, 1'b1, make_point(16, 16, 1, 0, 1));
        add_row('{0, 0, 16, 0, 100, 100, 200, 300}, 1'b1, make_point(0, 0, 0, 0, 1));
        add_row('{0, 0, 160, 0, 0, 160, 160, 160}, 1'b1, make_point(0, 0, 0, 0, 1));
        add_row('{0, 0, 16, 0, 32, 0, 48, 0}, 1'b1, make_point(0, 0, 0, 1, 1));
        add_row('{0, 0, 0, 0, 0, 0, 0, 0}, 1'b0, none);
        add_row('{0, 0, 64, 0, 32, 0, 96, 0}, 1'b0, none);
        add_row('{0, 0, 100, 0, 20, 0, 80, 0}, 1'b0, none);
        add_row('{0, 0, 50, 50, 0, 0, 50, 50}, 1'b0, none);
        add_row('{0, 0, 50, 0, 1, 0, 60, 0}, 1'b0, none);
        add_row('{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768}, 1'b0, none);
        add_row('{-32768, -32768, 32767, -32768, 0, -32768, 0, 32767}, 1'b0, none);
        add_row('{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767}, 1'b0, none);
        add_row('{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768}, 1'b0, none);
        add_row('{32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767}, 1'b0, none);
        add_row('{0, 0, 16, 16, 16, 16, 32, 0}, 1'b0, none);
        add_row('{0, 0, 1000, 1, 0, 1, 1000, 2}, 1'b0, none);
        add_row('{0, 0, 3, 1, 0, 0, 2, 1}, 1'b0, none);
        add_row('{-100, 7, 300, 11, 50, -200, 47, 400}, 1'b0, none);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_pair(directed_rows[i].coords, directed_rows[i].typed, directed_rows[i].want);
        run_random(100);

        drain_results();
        write_register(sip_pkg::REG_CROSS_EPS, 32'd0);
        write_register(sip_pkg::REG_POINT_EPS, 32'd0);
        write_register(REG_UNMAPPED, 32'hFFFF_FFFF);
        send_idle_pct = 73;
        recv_idle_pct = 26;
        run_random(90);

        drain_results();
        write_register(sip_pkg::REG_CROSS_EPS, 32'hFFFF_FFFF);
        write_register(sip_pkg::REG_POINT_EPS, 32'h0000_01FF);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 1'b1;
        run_random(60);

        drain_results();
        write_register(sip_pkg::REG_CROSS_EPS, 32'd4096);
        write_register(sip_pkg::REG_POINT_EPS, 32'd8);
        run_random(90);

        drain_results();
        $display("Sent %0d segment pairs over four register settings.", items_sent);
        $display("%0d points returned, %0d results from collinear pairs.",
                 points_seen, collinear_seen);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", errors);
            $display("Verification failed");
        end
        $finish;
    end
endmodule
